FILE: design/fpmm_pkg.sv
`default_nettype none
package fpmm_pkg;

    // matrix geometry and element widths
    localparam int MAX_DIM    = 8;
    localparam int DIM_BITS   = 3;
    localparam int CNT_BITS   = 4;
    localparam int ADDR_BITS  = 2 * DIM_BITS;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int VALUE_BITS = 16;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int SUM_BITS   = 40;

    // input item kinds
    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [1:0] CFG_COL_COUNT   = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } state_t;

    // tag that travels with each memory read through the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } issue_t;

    // one finished element handed to the output register
    typedef struct packed {
        logic                valid;
        logic [DIM_BITS-1:0] row;
        logic [DIM_BITS-1:0] col;
        logic                last;
    } emit_t;

endpackage
`default_nettype wire

FILE: design/fixed_point_matrix_multiply.sv
`default_nettype none
// Load items (A or B element) are accepted back to back while no compute is running.
// A compute item holds off input until the last result element has gone to the output
// register: each element reads both memories once for each of its inner_count terms,
// then waits as read, multiply and accumulate drain before the result is registered.
// aresetn is synchronous, active low: sizes return to 1, the element memories keep
// their contents and are undefined until loaded.
module fixed_point_matrix_multiply (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_row[2:0], out_col[5:3], product_value[45:6]
    output logic             m_tlast,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);
    import fpmm_pkg::*;

    logic [CNT_BITS-1:0]   row_count_reg;
    logic [CNT_BITS-1:0]   inner_count_reg;
    logic [CNT_BITS-1:0]   col_count_reg;
    logic [CNT_BITS-1:0]   cfg_size;
    logic                  cfg_fire;

    logic                  s_fire;
    logic [DIM_BITS-1:0]   ld_row;
    logic [DIM_BITS-1:0]   ld_col;
    logic [VALUE_BITS-1:0] ld_value;
    logic                  wr_a, wr_b, start;

    logic                  idle;
    issue_t                issue;
    emit_t                 emit;
    logic [ADDR_BITS-1:0]  a_addr, b_addr;
    logic [VALUE_BITS-1:0] a_data, b_data;
    logic signed [SUM_BITS-1:0] sum;
    logic                  acc_done;
    logic                  out_free;

    logic                  m_valid_reg;
    logic [DIM_BITS-1:0]   m_row_reg;
    logic [DIM_BITS-1:0]   m_col_reg;
    logic [SUM_BITS-1:0]   m_sum_reg;
    logic                  m_last_reg;

    // size registers, clamped to 1..MAX_DIM on write
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        priority if (cfg_data == '0) begin
            cfg_size = CNT_BITS'(1);
        end else if (cfg_data > CNT_BITS'(MAX_DIM)) begin
            cfg_size = CNT_BITS'(MAX_DIM);
        end else begin
            cfg_size = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= CNT_BITS'(1);
            inner_count_reg <= CNT_BITS'(1);
            col_count_reg   <= CNT_BITS'(1);
        end else if (cfg_fire) begin
            if (cfg_index == CFG_ROW_COUNT) begin
                row_count_reg <= cfg_size;
            end
            if (cfg_index == CFG_INNER_COUNT) begin
                inner_count_reg <= cfg_size;
            end
            if (cfg_index == CFG_COL_COUNT) begin
                col_count_reg <= cfg_size;
            end
        end
    end

    // input transfer decode
    assign s_tready = idle;
    assign s_fire   = s_tvalid && s_tready;
    assign ld_row   = s_tdata[2:0];
    assign ld_col   = s_tdata[5:3];
    assign ld_value = s_tdata[21:6];
    assign wr_a     = s_fire && (s_tuser == CMD_LOAD_A);
    assign wr_b     = s_fire && (s_tuser == CMD_LOAD_B);
    assign start    = s_fire && (s_tuser == CMD_COMPUTE);

    // element memories, addressed row*MAX_DIM+col
    fpmm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr ({ld_row, ld_col}),
        .wr_data (ld_value),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    fpmm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr ({ld_row, ld_col}),
        .wr_data (ld_value),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    // loop sequencer
    fpmm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .row_count   (row_count_reg),
        .inner_count (inner_count_reg),
        .col_count   (col_count_reg),
        .acc_done    (acc_done),
        .out_free    (out_free),
        .idle        (idle),
        .issue       (issue),
        .a_addr      (a_addr),
        .b_addr      (b_addr),
        .emit        (emit)
    );

    // multiply-accumulate datapath
    fpmm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .a_data  (a_data),
        .b_data  (b_data),
        .clear   (emit.valid),
        .sum     (sum),
        .done    (acc_done)
    );

    // output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_row_reg  <= emit.row;
            m_col_reg  <= emit.col;
            m_sum_reg  <= sum;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_sum_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

FILE: design/fpmm_ram.sv
`default_nettype none
module fpmm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: design/fpmm_mac.sv
`default_nettype none
module fpmm_mac (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire fpmm_pkg::issue_t                     issue,
    input  wire logic signed [fpmm_pkg::VALUE_BITS-1:0] a_data,
    input  wire logic signed [fpmm_pkg::VALUE_BITS-1:0] b_data,
    input  wire logic                                 clear,
    output logic signed      [fpmm_pkg::SUM_BITS-1:0]   sum,
    output logic                                      done
);
    import fpmm_pkg::*;

    issue_t                      tag_reg;
    issue_t                      ptag_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [SUM_BITS-1:0]  acc_reg;
    logic signed [SUM_BITS-1:0]  prod_ext;
    logic                        done_reg;

    // tags follow the memory read latency, then the multiplier stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg  <= '0;
            ptag_reg <= '0;
        end else begin
            tag_reg  <= issue;
            ptag_reg <= tag_reg;
        end
    end

    // registered product of the two read elements
    always_ff @(posedge aclk) begin
        prod_reg <= a_data * b_data;
    end

    assign prod_ext = SUM_BITS'(prod_reg);

    // accumulate, restarting on the first term of an element
    always_ff @(posedge aclk) begin
        if (ptag_reg.valid) begin
            if (ptag_reg.first) begin
                acc_reg <= prod_ext;
            end else begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    // element finished flag, held until the sequencer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (clear) begin
            done_reg <= 1'b0;
        end else if (ptag_reg.valid && ptag_reg.last) begin
            done_reg <= 1'b1;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: design/fpmm_ctrl.sv
`default_nettype none
module fpmm_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [fpmm_pkg::CNT_BITS-1:0]     row_count,
    input  wire logic [fpmm_pkg::CNT_BITS-1:0]     inner_count,
    input  wire logic [fpmm_pkg::CNT_BITS-1:0]     col_count,
    input  wire logic                              acc_done,
    input  wire logic                              out_free,
    output logic                                   idle,
    output fpmm_pkg::issue_t                       issue,
    output logic      [fpmm_pkg::ADDR_BITS-1:0]    a_addr,
    output logic      [fpmm_pkg::ADDR_BITS-1:0]    b_addr,
    output fpmm_pkg::emit_t                        emit
);
    import fpmm_pkg::*;

    state_t              state_reg, state_next;
    logic [DIM_BITS-1:0] i_reg, i_next;
    logic [DIM_BITS-1:0] j_reg, j_next;
    logic [DIM_BITS-1:0] k_reg, k_next;
    logic                k_end, j_end, i_end;

    assign k_end = (CNT_BITS'(k_reg) + CNT_BITS'(1)) == inner_count;
    assign j_end = (CNT_BITS'(j_reg) + CNT_BITS'(1)) == col_count;
    assign i_end = (CNT_BITS'(i_reg) + CNT_BITS'(1)) == row_count;

    // read addresses: A[i][k] and B[k][j]
    assign a_addr = {i_reg, k_reg};
    assign b_addr = {k_reg, j_reg};

    // state and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // next state, counter stepping and outputs
    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        idle        = 1'b0;
        issue       = '0;
        emit.valid  = 1'b0;
        emit.row    = i_reg;
        emit.col    = j_reg;
        emit.last   = i_end && j_end;
        unique case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    state_next = ST_READ;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_READ: begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = k_end;
                if (k_end) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + DIM_BITS'(1);
                end
            end
            ST_DRAIN: begin
                if (acc_done && out_free) begin
                    emit.valid = 1'b1;
                    if (j_end) begin
                        j_next = '0;
                        if (i_end) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + DIM_BITS'(1);
                            state_next = ST_READ;
                        end
                    end else begin
                        j_next     = j_reg + DIM_BITS'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
